>>> design/gtep_pkg.sv
package gtep_pkg;

  localparam int unsigned ID_BYTES_MAX = 32;

  localparam int unsigned ID_LEN_NARROW = (ID_BYTES_MAX < 20) ? ID_BYTES_MAX : 20;
  localparam int unsigned ID_LEN_WIDE   = (ID_BYTES_MAX < 32) ? ID_BYTES_MAX : 32;

  localparam logic [1:0] KIND_ID_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] FAULT_NONE       = 2'd0;
  localparam logic [1:0] FAULT_EMPTY_MODE = 2'd1;
  localparam logic [1:0] FAULT_EMPTY_NAME = 2'd2;
  localparam logic [1:0] FAULT_TRUNCATED  = 2'd3;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [2:0] GITLINK_MODE_LEN = 3'd6;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] id_byte;
    logic [4:0] id_position;
    logic       id_complete;
    logic       body_done;
    logic [1:0] fault_code;
  } out_beat_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [2:0] mode_count;
    logic       mode_is_gitlink;
    logic       name_seen;
    logic [4:0] id_count;
    logic       error_hold;
  } parse_state_t;

  function automatic logic [7:0] gitlink_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h31;
      3'd1:    c = 8'h36;
      default: c = 8'h30;
    endcase
    return c;
  endfunction

endpackage

>>> design/git_tree_entry_parser_unit.sv
// Parses the body of a git tree object at one byte per clock cycle while the result
// side does not stall, and returns at most one result beat per byte: an id byte of
// every kept entry, a clean end of body after a trailing submodule entry, or an error
// with its fault code. Each byte passes through an input register, the parse step
// and a result register. The user must write the id length register only while no
// byte is in flight; the block itself does not enforce this.
module git_tree_entry_parser_unit
  import gtep_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_wr_en_i,
  input  logic      cfg_wr_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic      wide_ids_q;
  logic      s1_valid_q;
  in_beat_t  s1_beat_q;
  logic      out_valid_q;
  out_beat_t out_beat_q;
  logic      advance;
  logic      accept;
  logic      res_valid;
  out_beat_t res;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_ids_q <= 1'b0;
    end else if (cfg_wr_en_i) begin
      wide_ids_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_beat_q <= in_beat_i;
    end
  end

  gtep_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wide_ids_i  (wide_ids_q),
    .step_i      (advance),
    .beat_i      (s1_beat_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_beat_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

>>> design/gtep_parser.sv
module gtep_parser
  import gtep_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wide_ids_i,
  input  logic      step_i,
  input  in_beat_t  beat_i,
  output logic      res_valid_o,
  output out_beat_t res_o
);

  localparam logic [1:0] PH_MODE = 2'd0;
  localparam logic [1:0] PH_NAME = 2'd1;
  localparam logic [1:0] PH_ID   = 2'd2;

  localparam logic [5:0] LEN_NARROW = 6'(ID_LEN_NARROW);
  localparam logic [5:0] LEN_WIDE   = 6'(ID_LEN_WIDE);

  parse_state_t st_q, st_d, entry_start;
  logic [7:0]   b;
  logic         fin;
  logic         raise;
  logic [1:0]   fault;
  logic [5:0]   id_len;
  logic         complete;
  logic         skip;

  always_comb begin
    entry_start                 = '0;
    entry_start.phase           = PH_MODE;
    entry_start.mode_is_gitlink = 1'b1;
  end

  assign b        = beat_i.body_byte;
  assign fin      = beat_i.final_byte;
  assign id_len   = wide_ids_i ? LEN_WIDE : LEN_NARROW;
  assign complete = ({1'b0, st_q.id_count} + 6'd1) >= id_len;
  assign skip     = st_q.mode_is_gitlink && (st_q.mode_count == GITLINK_MODE_LEN);

  always_comb begin
    st_d        = st_q;
    raise       = 1'b0;
    fault       = FAULT_NONE;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (st_q.error_hold) begin
      if (fin) begin
        st_d = entry_start;
      end
    end else begin
      case (st_q.phase)
        PH_MODE: begin
          if (b == CHAR_SPACE) begin
            if (st_q.mode_count == 3'd0) begin
              raise = 1'b1;
              fault = FAULT_EMPTY_MODE;
            end else if (fin) begin
              raise = 1'b1;
              fault = FAULT_TRUNCATED;
            end else begin
              st_d.phase     = PH_NAME;
              st_d.name_seen = 1'b0;
            end
          end else begin
            if (st_q.mode_count >= GITLINK_MODE_LEN || b != gitlink_char(st_q.mode_count)) begin
              st_d.mode_is_gitlink = 1'b0;
            end
            if (st_q.mode_count != 3'd7) begin
              st_d.mode_count = st_q.mode_count + 3'd1;
            end
            if (fin) begin
              raise = 1'b1;
              fault = FAULT_TRUNCATED;
            end
          end
        end
        PH_NAME: begin
          if (b == CHAR_NUL) begin
            if (!st_q.name_seen) begin
              raise = 1'b1;
              fault = FAULT_EMPTY_NAME;
            end else if (fin) begin
              raise = 1'b1;
              fault = FAULT_TRUNCATED;
            end else begin
              st_d.phase    = PH_ID;
              st_d.id_count = 5'd0;
            end
          end else begin
            st_d.name_seen = 1'b1;
            if (fin) begin
              raise = 1'b1;
              fault = FAULT_TRUNCATED;
            end
          end
        end
        PH_ID: begin
          if (fin && !complete) begin
            raise = 1'b1;
            fault = FAULT_TRUNCATED;
          end else begin
            if (complete) begin
              st_d = entry_start;
            end else begin
              st_d.id_count = st_q.id_count + 5'd1;
            end
            if (!skip) begin
              res_valid_o       = 1'b1;
              res_o.result_kind = KIND_ID_BYTE;
              res_o.id_byte     = b;
              res_o.id_position = st_q.id_count;
              res_o.id_complete = complete;
              res_o.body_done   = complete && fin;
            end else if (complete && fin) begin
              res_valid_o       = 1'b1;
              res_o.result_kind = KIND_DONE;
              res_o.body_done   = 1'b1;
            end
          end
        end
        default: begin
          st_d = entry_start;
        end
      endcase
      if (raise) begin
        st_d              = entry_start;
        st_d.error_hold   = !fin;
        res_valid_o       = 1'b1;
        res_o             = '0;
        res_o.result_kind = KIND_ERROR;
        res_o.fault_code  = fault;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= entry_start;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

>>> design/gtep_checker.sv
module gtep_checker
  import gtep_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_beat_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("Stalled result beat changed.");

  a_fault_iff_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_beat_o.result_kind == KIND_ERROR) ==
                     (out_beat_o.fault_code != FAULT_NONE)))
    else $error("Fault code does not match result kind.");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.result_kind == KIND_ERROR |->
      !out_beat_o.body_done && !out_beat_o.id_complete && out_beat_o.id_byte == 8'd0)
    else $error("Error beat carries id or done fields.");

  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.result_kind == KIND_DONE |->
      out_beat_o.body_done && out_beat_o.id_position == 5'd0)
    else $error("Done beat without body_done.");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.result_kind == KIND_ID_BYTE && out_beat_o.body_done |->
      out_beat_o.id_complete)
    else $error("Body closed in the middle of an id.");

endmodule

bind git_tree_entry_parser_unit gtep_checker u_gtep_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);

>>> verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gtep_pkg::*;

  typedef enum logic [1:0] {ST_MODE, ST_NAME, ST_ID} parse_phase_e;

  localparam logic [47:0] SUBMODULE_MODE = "160000";
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 150;

  // Tracks the parse state of the tree body and keeps the result beats that
  // the accepted bytes must produce, oldest first.
  class entry_id_tracker;
    parse_phase_e phase;
    logic [2:0] mode_len;
    bit submodule_prefix;
    bit name_seen;
    logic [4:0] id_idx;
    bit skipping;
    bit wide;
    out_beat_t expected_q[$];
    int mismatches;
    int kind_count[3];
    int fault_count[4];

    function new();
      restart();
      skipping = 1'b0;
      wide = 1'b0;
      mismatches = 0;
    endfunction

    function void restart();
      phase = ST_MODE;
      mode_len = '0;
      submodule_prefix = 1'b1;
      name_seen = 1'b0;
      id_idx = '0;
    endfunction

    function void set_wide(logic w);
      wide = w;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push(logic [1:0] kind, logic [7:0] b, logic [4:0] pos, logic last,
                       logic done, logic [1:0] fault);
      expected_q.push_back('{result_kind: kind, id_byte: b, id_position: pos,
                             id_complete: last, body_done: done, fault_code: fault});
    endfunction

    function void flag(logic [1:0] fault, logic fin);
      push(KIND_ERROR, 8'h00, 5'd0, 1'b0, 1'b0, fault);
      restart();
      skipping = !fin;
    endfunction

    function void note_byte(in_beat_t beat);
      logic [7:0] b;
      logic fin;
      logic last;
      logic drop;
      logic [4:0] pos;
      int unsigned len;
      int k;
      b = beat.body_byte;
      fin = beat.final_byte;
      len = wide ? ID_LEN_WIDE : ID_LEN_NARROW;
      if (skipping) begin
        if (fin) begin
          skipping = 1'b0;
          restart();
        end
        return;
      end
      case (phase)
        ST_MODE: begin
          if (b == CHAR_SPACE) begin
            if (mode_len == 0) flag(FAULT_EMPTY_MODE, fin);
            else if (fin) flag(FAULT_TRUNCATED, fin);
            else begin
              phase = ST_NAME;
              name_seen = 1'b0;
            end
          end else begin
            k = int'(mode_len);
            if (k >= 6) submodule_prefix = 1'b0;
            else if (b != SUBMODULE_MODE[8 * (5 - k) +: 8]) submodule_prefix = 1'b0;
            if (mode_len < 7) mode_len = mode_len + 3'd1;
            if (fin) flag(FAULT_TRUNCATED, fin);
          end
        end
        ST_NAME: begin
          if (b == CHAR_NUL) begin
            if (!name_seen) flag(FAULT_EMPTY_NAME, fin);
            else if (fin) flag(FAULT_TRUNCATED, fin);
            else begin
              phase = ST_ID;
              id_idx = '0;
            end
          end else begin
            name_seen = 1'b1;
            if (fin) flag(FAULT_TRUNCATED, fin);
          end
        end
        default: begin
          pos = id_idx;
          last = (int'(pos) + 1 >= len);
          drop = submodule_prefix && (mode_len == GITLINK_MODE_LEN);
          if (fin && !last) begin
            flag(FAULT_TRUNCATED, fin);
            return;
          end
          if (last) restart();
          else id_idx = pos + 5'd1;
          if (!drop) push(KIND_ID_BYTE, b, pos, last, last && fin, FAULT_NONE);
          else if (last && fin) push(KIND_DONE, 8'h00, 5'd0, 1'b0, 1'b1, FAULT_NONE);
        end
      endcase
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result beat with nothing expected: %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (want.result_kind <= KIND_ERROR) kind_count[want.result_kind]++;
      if (want.result_kind == KIND_ERROR) fault_count[want.fault_code]++;
      if (got.result_kind !== want.result_kind || got.id_byte !== want.id_byte ||
          got.id_position !== want.id_position || got.id_complete !== want.id_complete ||
          got.body_done !== want.body_done || got.fault_code !== want.fault_code) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: want kind %0d byte %02h pos %0d last %0b done %0b fault %0d",
                   want.result_kind, want.id_byte, want.id_position, want.id_complete,
                   want.body_done, want.fault_code);
          $display("          got  kind %0d byte %02h pos %0d last %0b done %0b fault %0d",
                   got.result_kind, got.id_byte, got.id_position, got.id_complete,
                   got.body_done, got.fault_code);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_wr_en_i = 1'b0;
  logic cfg_wr_data_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_beat_t in_beat_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  entry_id_tracker sb = new();
  logic [7:0] body_q[$];
  bit cur_wide = 1'b0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  int burst_left = 0;
  int bytes_sent = 0;
  int bodies_sent = 0;
  int hold_total = 0;

  git_tree_entry_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_beat_i     (in_beat_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_beat_o    (out_beat_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(in_beat_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_beat_o);
    end
  end

  // The result side switches between stall patterns and, on request, holds off
  // for a long stretch so that the block backs up into its input.
  initial begin : result_side
    int hold_left;
    int mode_left;
    int stall_mode;
    hold_left = 0;
    mode_left = 0;
    stall_mode = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 100);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        hold_total++;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  task automatic pace();
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 24);
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_valid_i <= 1'b1;
    in_beat_i <= '{body_byte: b, final_byte: fin};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    pace();
  endtask

  task automatic send_body();
    for (int i = 0; i < body_q.size(); i++) send_byte(body_q[i], i == body_q.size() - 1);
    body_q.delete();
    bodies_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_id_width(input logic w);
    drain();
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= w;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    sb.set_wide(w);
    cur_wide = w;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endtask

  task automatic add_fill(input int n, input logic [7:0] v);
    repeat (n) body_q.push_back(v);
  endtask

  task automatic add_random(input int n, input bit nonzero);
    repeat (n) body_q.push_back(8'(nonzero ? $urandom_range(1, 255) : $urandom_range(0, 255)));
  endtask

  task automatic add_entry(input int sel, input int name_len, input int id_len);
    logic [7:0] b;
    case (sel)
      0: add_text("100644");
      1: add_text("40000");
      2, 3: add_text("160000");
      4: add_text("1600000");
      5: add_text("16000");
      6: begin
        repeat ($urandom_range(1, 9)) begin
          do b = 8'($urandom_range(0, 255)); while (b == CHAR_SPACE);
          body_q.push_back(b);
        end
      end
      default: ;
    endcase
    body_q.push_back(CHAR_SPACE);
    add_random(name_len, 1'b1);
    body_q.push_back(CHAR_NUL);
    add_random(id_len, 1'b0);
  endtask

  task automatic build_random_body();
    int entries;
    int flaw;
    int bad;
    int sel;
    int nlen;
    int full;
    full = cur_wide ? ID_LEN_WIDE : ID_LEN_NARROW;
    flaw = $urandom_range(0, 9);
    if (flaw == 9) begin
      add_random($urandom_range(1, 30), 1'b0);
      return;
    end
    entries = $urandom_range(1, 4);
    bad = $urandom_range(0, entries - 1);
    for (int i = 0; i < entries; i++) begin
      sel = $urandom_range(0, 6);
      nlen = $urandom_range(1, 5);
      if (flaw == 7 && i == bad) sel = 7;
      if (flaw == 8 && i == bad) nlen = 0;
      add_entry(sel, nlen, full);
    end
    if (flaw == 6) body_q = body_q[0:$urandom_range(0, body_q.size() - 2)];
  endtask

  task automatic random_phase(input int target);
    while (bytes_sent < target) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      build_random_body();
      send_body();
      if ($urandom_range(0, 7) == 0) drain();
    end
    no_gaps = 1'b0;
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_id_width(1'b0);
    add_text(" ");
    send_body();
    add_text("1");
    send_body();
    add_text("1 ");
    send_body();
    add_text("1 ");
    body_q.push_back(CHAR_NUL);
    add_text("z z");
    send_body();
    add_text("1 ");
    body_q.push_back(CHAR_NUL);
    send_body();
    add_text("1 a");
    send_body();
    add_text("1 a");
    body_q.push_back(CHAR_NUL);
    send_body();
    add_text("1 a");
    body_q.push_back(CHAR_NUL);
    add_fill(5, 8'hFF);
    send_body();
    add_text("1 ");
    body_q.push_back(8'hFF);
    body_q.push_back(CHAR_NUL);
    add_fill(ID_LEN_NARROW, 8'h00);
    add_text("7 ");
    body_q.push_back(8'h01);
    body_q.push_back(CHAR_NUL);
    add_fill(ID_LEN_NARROW, 8'hFF);
    send_body();
    add_entry(2, 1, ID_LEN_NARROW);
    send_body();
    add_entry(2, 2, ID_LEN_NARROW);
    add_entry(4, 1, ID_LEN_NARROW);
    add_entry(5, 1, ID_LEN_NARROW);
    add_text("99999999 n");
    body_q.push_back(CHAR_NUL);
    add_random(ID_LEN_NARROW, 1'b0);
    send_body();

    set_id_width(1'b1);
    no_gaps = 1'b1;
    hold_req = 1'b1;
    repeat (3) add_entry(0, 3, ID_LEN_WIDE);
    add_entry(2, 3, ID_LEN_WIDE);
    send_body();
    no_gaps = 1'b0;
    drain();
    random_phase(bytes_sent + 170);

    set_id_width(1'b0);
    random_phase(bytes_sent + 150);

    set_id_width(1'b1);
    random_phase(bytes_sent + 140);

    drain();
    $display("Sent %0d body bytes in %0d bodies with 20- and 32-byte ids.",
             bytes_sent, bodies_sent);
    $display("Expected %0d id bytes, %0d clean ends, faults %0d/%0d/%0d; hold %0d cycles.",
             sb.kind_count[0], sb.kind_count[1], sb.fault_count[1], sb.fault_count[2],
             sb.fault_count[3], hold_total);
    if (sb.mismatches == 0 && sb.pending() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
